@@ rtl/core/clws_pkg.sv @@
// Shared types and constants for the character LCD write sequencer.
// Used by clws_ctrl, clws_datapath and char_lcd_write_sequencer.
// No dependencies.
package clws_pkg;

  // Operation codes carried on the input side.
  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_CMD     = 2'd1,
    OP_CURSOR  = 2'd2,
    OP_POWERUP = 2'd3
  } op_t;

  // Steps of the power-up command sequence.
  typedef enum logic [1:0] {
    STEP_FUNC  = 2'd0,
    STEP_DISP  = 2'd1,
    STEP_CLEAR = 2'd2
  } step_t;

  // Which hold time goes with an item.
  typedef enum logic [1:0] {
    HOLD_STROBE = 2'd0,
    HOLD_START  = 2'd1,
    HOLD_GAP1   = 2'd2,
    HOLD_GAP2   = 2'd3
  } hold_sel_t;

  localparam int unsigned HOLD_W   = 6;
  localparam int unsigned HOLD_MAX = 63;

  localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;

  localparam logic [HOLD_W-1:0] GAP1_MS = 6'd1;
  localparam logic [HOLD_W-1:0] GAP2_MS = 6'd2;

  // The RW pin is always driven for a write.
  localparam logic RW_WRITE = 1'b0;

  // Controller to datapath commands.
  typedef struct packed {
    logic      load_in;
    logic      load_step;
    step_t     step;
    logic      emit;
    logic      en;
    logic      zero_bus;
    logic      nib_lo;
    hold_sel_t hold_sel;
    logic      last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
    logic bus8;
  } stat_t;

endpackage

@@ rtl/core/clws_ctrl.sv @@
// Controller state machine for the character LCD write sequencer.
// Walks the strobe, nibble and power-up steps and commands clws_datapath.
// Depends on clws_pkg.
module clws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  clws_pkg::stat_t   stat,
  output clws_pkg::cmd_t    cmd
);
  import clws_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_HI    = 5'b00100,
    S_LO    = 5'b01000,
    S_GAP   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   nib_lo, nib_lo_next;
  logic   pwr, pwr_next;
  step_t  step, step_next;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      nib_lo <= 1'b0;
      pwr    <= 1'b0;
      step   <= STEP_FUNC;
    end else begin
      state  <= state_next;
      nib_lo <= nib_lo_next;
      pwr    <= pwr_next;
      step   <= step_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and command decode. Every non-idle state emits one item and
  // waits while the output register is still occupied.
  always_comb begin
    state_next  = state;
    nib_lo_next = nib_lo;
    pwr_next    = pwr;
    step_next   = step;
    cmd         = '0;
    cmd.nib_lo  = nib_lo;
    cmd.step    = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          nib_lo_next = 1'b0;
          step_next   = STEP_FUNC;
          if (op_t'(in_op) == OP_POWERUP) begin
            pwr_next   = 1'b1;
            state_next = S_START;
          end else begin
            pwr_next   = 1'b0;
            state_next = S_HI;
          end
        end
      end
      S_START: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.zero_bus  = 1'b1;
          cmd.hold_sel  = HOLD_START;
          cmd.load_step = 1'b1;
          cmd.step      = STEP_FUNC;
          nib_lo_next   = 1'b0;
          state_next    = S_HI;
        end
      end
      S_HI: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.en       = 1'b1;
          cmd.hold_sel = HOLD_STROBE;
          state_next   = S_LO;
        end
      end
      S_LO: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.hold_sel = HOLD_STROBE;
          if (!stat.bus8 && !nib_lo) begin
            // High nibble done; send the low nibble next.
            nib_lo_next = 1'b1;
            state_next  = S_HI;
          end else if (pwr && step != STEP_CLEAR) begin
            state_next = S_GAP;
          end else begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_GAP: begin
        if (stat.out_free) begin
          // Repeat the previous pin state, then load the next command byte.
          cmd.emit      = 1'b1;
          cmd.hold_sel  = (step == STEP_FUNC) ? HOLD_GAP1 : HOLD_GAP2;
          cmd.load_step = 1'b1;
          cmd.step      = step_t'(step + 2'd1);
          step_next     = step_t'(step + 2'd1);
          nib_lo_next   = 1'b0;
          state_next    = S_HI;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/clws_datapath.sv @@
// Datapath for the character LCD write sequencer: byte and RS registers,
// bus value selection, hold time selection, output register and bus mode.
// Depends on clws_pkg.
module clws_datapath #(
  parameter logic [5:0] START_HOLD  = 6'd50,
  parameter logic [5:0] STROBE_HOLD = 6'd1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_byte,
  input  logic             in_row,
  input  logic [5:0]       in_col,
  input  clws_pkg::cmd_t   cmd,
  output clws_pkg::stat_t  stat,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_rs,
  output logic             out_en,
  output logic [7:0]       out_bus,
  output logic [5:0]       out_hold,
  output logic             out_last
);
  import clws_pkg::*;

  logic       bus8;
  logic [7:0] byte_q;
  logic       rs_q;
  logic [7:0] bus_val;
  logic [5:0] hold_val;
  logic [7:0] step_byte;

  // Bus mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus8 <= 1'b0;
    end else if (cfg_wr_en) begin
      bus8 <= cfg_wr_data;
    end
  end

  // Command byte for each power-up step.
  always_comb begin
    case (cmd.step)
      STEP_FUNC:  step_byte = bus8 ? CMD_FUNC_8BIT : CMD_FUNC_4BIT;
      STEP_DISP:  step_byte = CMD_DISP_ON;
      default:    step_byte = CMD_CLEAR;
    endcase
  end

  // Byte being written and its register select level.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rs_q   <= (op_t'(in_op) == OP_DATA);
      byte_q <= (op_t'(in_op) == OP_CURSOR) ? {1'b1, in_row, in_col} : in_byte;
    end else if (cmd.load_step) begin
      rs_q   <= 1'b0;
      byte_q <= step_byte;
    end
  end

  // Pin value: zero for the start item, else the whole byte in 8-bit mode, one nibble on bits 7:4 otherwise.
  always_comb begin
    if (cmd.zero_bus) begin
      bus_val = 8'h00;
    end else if (bus8) begin
      bus_val = byte_q;
    end else if (cmd.nib_lo) begin
      bus_val = {byte_q[3:0], 4'h0};
    end else begin
      bus_val = {byte_q[7:4], 4'h0};
    end
  end

  always_comb begin
    case (cmd.hold_sel)
      HOLD_STROBE: hold_val = STROBE_HOLD;
      HOLD_START:  hold_val = START_HOLD;
      HOLD_GAP1:   hold_val = GAP1_MS;
      default:     hold_val = GAP2_MS;
    endcase
  end

  // Output register: valid flag and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rs   <= cmd.zero_bus ? 1'b0 : rs_q;
      out_en   <= cmd.en;
      out_bus  <= bus_val;
      out_hold <= hold_val;
      out_last <= cmd.last;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.bus8     = bus8;

endmodule

@@ rtl/core/char_lcd_write_sequencer.sv @@
// Character LCD write sequencer, top level. Depends on clws_pkg, clws_ctrl
// and clws_datapath.
// After an item is accepted the controller moves to its start or high-nibble state, which
// emits the first pin-state item into the output register once that register is free.
// A new item is accepted only in idle, after the run's last pin-state item is emitted;
// output stalls hold the controller in its current state.
// Reset: synchronous, active high; the controller returns to idle, the output
// register empties and the bus mode returns to 4-bit.
module char_lcd_write_sequencer #(
  parameter int unsigned STARTUP_WAIT_MS = 50,
  parameter int unsigned STROBE_MS       = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // bus_is_8bit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_value[7:0], row[8], col[14:9], zero[15]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // rw[0], enable[1], data_bus[9:2], hold_ms[15:10]
  output logic        m_axis_tuser,   // rs[0]
  output logic        m_axis_tlast
);
  import clws_pkg::*;

  // Hold times saturate at the field maximum.
  localparam int unsigned START_SAT  =
    (STARTUP_WAIT_MS > HOLD_MAX) ? HOLD_MAX : STARTUP_WAIT_MS;
  localparam int unsigned STROBE_SAT =
    (STROBE_MS > HOLD_MAX) ? HOLD_MAX : STROBE_MS;
  localparam logic [5:0] START_HOLD  = START_SAT[5:0];
  localparam logic [5:0] STROBE_HOLD = STROBE_SAT[5:0];

  cmd_t       cmd;
  stat_t      stat;
  logic       out_en;
  logic [7:0] out_bus;
  logic [5:0] out_hold;

  clws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clws_datapath #(
    .START_HOLD  (START_HOLD),
    .STROBE_HOLD (STROBE_HOLD)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (s_axis_tuser),
    .in_byte     (s_axis_tdata[7:0]),
    .in_row      (s_axis_tdata[8]),
    .in_col      (s_axis_tdata[14:9]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_rs      (m_axis_tuser),
    .out_en      (out_en),
    .out_bus     (out_bus),
    .out_hold    (out_hold),
    .out_last    (m_axis_tlast)
  );

  // Output item packing.
  assign m_axis_tdata = {out_hold, out_bus, out_en, RW_WRITE};

  // The controller never overwrites an item that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("item emitted into an occupied output register");

  // An accepted item keeps the input closed while its run is produced.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened right after an accepted item");

  // A run never ends with the enable strobe high.
  a_last_enable_low: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> !m_axis_tlast)
    else $error("last item of a run has enable high");

  // Starting a run only happens with no emit in the same cycle.
  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> !cmd.emit)
    else $error("emit while loading a new item");

endmodule

@@ dv/tb_char_lcd_write_sequencer.sv @@
// Self-checking testbench for char_lcd_write_sequencer: LCD write requests in, pin-state items out.
// Depends on clws_pkg and the RTL top; runs a directed table, then random phases in both bus modes.
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer;
  import clws_pkg::*;

  localparam int unsigned STARTUP_MS = 50;
  localparam int unsigned STROBE_MS  = 1;
  localparam int unsigned PIN_HOLD_MAX = 63;

  // LCD command bytes used by the power-up sequence.
  localparam logic [7:0] LCD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;

  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned ITEMS_PER_PHASE  = 32;
  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned LIMIT_CYCLES     = 400000;
  localparam int unsigned MAX_PRINTED_ERRS = 100;

  // One pin-state item as seen on the output side.
  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [7:0] bus;
    logic [5:0] hold;
    logic       last;
  } pin_state_t;

  // One row of the directed table.
  typedef struct packed {
    logic       bus8;
    op_t        op;
    logic [7:0] byte_val;
    logic       row;
    logic [5:0] col;
    logic       typed;
    pin_state_t first;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // byte_value[7:0], row[8], col[14:9], zero[15]
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // rw[0], enable[1], data_bus[9:2], hold_ms[15:10]
  logic        m_axis_tuser;        // rs[0]
  logic        m_axis_tlast;

  // Side information that travels with the item being offered.
  logic       stim_typed = 1'b0;
  pin_state_t stim_first = '0;

  // Predictor state and expected pin states.
  logic       lcd_bus8 = 1'b0;
  pin_state_t run_q[$];
  pin_state_t pending_pins[$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned pins_seen = 0;
  int unsigned ops_seen[4] = '{0, 0, 0, 0};
  logic        send_calm = 1'b0;
  logic        recv_calm = 1'b0;
  int unsigned stall_left = 0;

  dir_row_t dir_tbl[17];

  char_lcd_write_sequencer #(
    .STARTUP_WAIT_MS(STARTUP_MS),
    .STROBE_MS(STROBE_MS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Counts one mismatch and prints it while under the print limit.
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (err_count < MAX_PRINTED_ERRS) begin
      $display("ERROR cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
    end
    err_count++;
  endtask

  // Appends one pin state to the run under construction, saturating the hold.
  function automatic void add_state(logic rs, logic en, logic [7:0] bus, int unsigned ms);
    pin_state_t ps;
    ps.rs = rs;
    ps.rw = 1'b0;
    ps.en = en;
    ps.bus = bus;
    ps.hold = (ms > PIN_HOLD_MAX) ? 6'(PIN_HOLD_MAX) : 6'(ms);
    ps.last = 1'b0;
    run_q.push_back(ps);
  endfunction

  // Enable high then enable low for one bus value.
  function automatic void add_strobe(logic rs, logic [7:0] bus);
    add_state(rs, 1'b1, bus, STROBE_MS);
    add_state(rs, 1'b0, bus, STROBE_MS);
  endfunction

  // A byte is one strobe in 8-bit mode, or high then low nibble on bits 7:4.
  function automatic void add_byte(logic rs, logic [7:0] b);
    if (lcd_bus8) begin
      add_strobe(rs, b);
    end else begin
      add_strobe(rs, b & 8'hF0);
      add_strobe(rs, {b[3:0], 4'h0});
    end
  endfunction

  // A gap repeats the previous pin state with a new hold.
  function automatic void add_gap(int unsigned ms);
    pin_state_t prev;
    prev = run_q[$];
    add_state(prev.rs, prev.en, prev.bus, ms);
  endfunction

  // Builds the full run of pin states that one request produces.
  function automatic void plan_pin_run(op_t op, logic [7:0] b, logic row, logic [5:0] col);
    run_q.delete();
    case (op)
      OP_DATA: add_byte(1'b1, b);
      OP_CMD: add_byte(1'b0, b);
      OP_CURSOR: add_byte(1'b0, 8'(128 + row * 64 + col));
      default: begin
        add_state(1'b0, 1'b0, 8'h00, STARTUP_MS);
        add_byte(1'b0, lcd_bus8 ? LCD_FUNC_8BIT : LCD_FUNC_4BIT);
        add_gap(1);
        add_byte(1'b0, LCD_DISP_ON);
        add_gap(2);
        add_byte(1'b0, LCD_CLEAR);
      end
    endcase
    run_q[run_q.size() - 1].last = 1'b1;
  endfunction

  // Watches both handshakes and the register port; predicts and checks.
  always @(posedge clk) begin
    pin_state_t got;
    pin_state_t want;
    if (rst) begin
      lcd_bus8 = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lcd_bus8 = cfg_wr_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        plan_pin_run(op_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8],
                     s_axis_tdata[14:9]);
        // Typed directed rows carry a hand-written first pin state.
        if (stim_typed) begin
          run_q[0] = stim_first;
        end
        foreach (run_q[i]) pending_pins.push_back(run_q[i]);
        ops_seen[s_axis_tuser]++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        pins_seen++;
        got.rs = m_axis_tuser;
        got.rw = m_axis_tdata[0];
        got.en = m_axis_tdata[1];
        got.bus = m_axis_tdata[9:2];
        got.hold = m_axis_tdata[15:10];
        got.last = m_axis_tlast;
        if (pending_pins.size() == 0) begin
          report_mismatch("unexpected pin-state item", m_axis_tdata, 0);
        end else begin
          want = pending_pins.pop_front();
          if (got.rs != want.rs) report_mismatch("rs", got.rs, want.rs);
          if (got.rw != want.rw) report_mismatch("rw", got.rw, want.rw);
          if (got.en != want.en) report_mismatch("enable", got.en, want.en);
          if (got.bus != want.bus) report_mismatch("data_bus", got.bus, want.bus);
          if (got.hold != want.hold) report_mismatch("hold_ms", got.hold, want.hold);
          if (got.last != want.last) report_mismatch("last", got.last, want.last);
        end
      end
    end
  end

  // Output back-pressure: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin
    int unsigned pick;
    pick = $urandom_range(99);
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_calm || pick < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left <= (pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end
    if ($urandom_range(149) == 0) begin
      recv_calm <= ~recv_calm;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d pin states outstanding", cycle_count,
               pending_pins.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one request after a random idle gap and waits for it to be taken.
  task automatic send_item(op_t op, logic [7:0] b, logic row, logic [5:0] col, logic typed,
                           pin_state_t first);
    int unsigned pick;
    int unsigned idle;
    pick = $urandom_range(99);
    if (send_calm || pick < 45) idle = 0;
    else if (pick < 90) idle = $urandom_range(1, 3);
    else idle = $urandom_range(6, 30);
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, col, row, b};
    s_axis_tuser <= op;
    stim_typed <= typed;
    stim_first <= first;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every expected pin state has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  // Changes the bus mode once the block has gone idle.
  task automatic set_bus_mode(logic bus8);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= bus8;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus: reset, directed table, then random phases in alternating bus modes.
  initial begin
    logic       cur_bus8;
    int unsigned pick;
    op_t        op;
    dir_tbl = '{
      '{1'b0, OP_DATA,    8'h00, 1'b0, 6'd0,  1'b1, '{1'b1, 1'b0, 1'b1, 8'h00, 6'd1, 1'b0}},
      '{1'b0, OP_DATA,    8'hFF, 1'b1, 6'd63, 1'b1, '{1'b1, 1'b0, 1'b1, 8'hF0, 6'd1, 1'b0}},
      '{1'b0, OP_DATA,    8'hA5, 1'b0, 6'd21, 1'b0, '0},
      '{1'b0, OP_CMD,     8'h01, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 6'd1, 1'b0}},
      '{1'b0, OP_CMD,     8'hFF, 1'b1, 6'd42, 1'b0, '0},
      '{1'b0, OP_CURSOR,  8'hFF, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 8'h80, 6'd1, 1'b0}},
      '{1'b0, OP_CURSOR,  8'h00, 1'b1, 6'd63, 1'b1, '{1'b0, 1'b0, 1'b1, 8'hF0, 6'd1, 1'b0}},
      '{1'b0, OP_CURSOR,  8'h55, 1'b1, 6'd0,  1'b0, '0},
      '{1'b0, OP_CURSOR,  8'hAA, 1'b0, 6'd63, 1'b0, '0},
      '{1'b0, OP_POWERUP, 8'h00, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 6'd50, 1'b0}},
      '{1'b1, OP_DATA,    8'h00, 1'b1, 6'd63, 1'b1, '{1'b1, 1'b0, 1'b1, 8'h00, 6'd1, 1'b0}},
      '{1'b1, OP_DATA,    8'hFF, 1'b0, 6'd0,  1'b1, '{1'b1, 1'b0, 1'b1, 8'hFF, 6'd1, 1'b0}},
      '{1'b1, OP_CMD,     8'h5A, 1'b0, 6'd5,  1'b0, '0},
      '{1'b1, OP_CURSOR,  8'h00, 1'b1, 6'd63, 1'b1, '{1'b0, 1'b0, 1'b1, 8'hFF, 6'd1, 1'b0}},
      '{1'b1, OP_CURSOR,  8'hFF, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 8'h80, 6'd1, 1'b0}},
      '{1'b1, OP_POWERUP, 8'hFF, 1'b1, 6'd63, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 6'd50, 1'b0}},
      '{1'b0, OP_DATA,    8'h3C, 1'b1, 6'd17, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, starting from an explicit 4-bit setting.
    cur_bus8 = 1'b0;
    set_bus_mode(cur_bus8);
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].bus8 != cur_bus8) begin
        cur_bus8 = dir_tbl[i].bus8;
        set_bus_mode(cur_bus8);
      end
      send_item(dir_tbl[i].op, dir_tbl[i].byte_val, dir_tbl[i].row, dir_tbl[i].col,
                dir_tbl[i].typed, dir_tbl[i].first);
    end

    // Random phases; odd phases open with a back-to-back burst.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_bus_mode(ph % 2 == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_calm <= (ph % 2 == 1) && (n < 10);
        pick = $urandom_range(99);
        if (pick < 35) op = OP_DATA;
        else if (pick < 60) op = OP_CMD;
        else if (pick < 88) op = OP_CURSOR;
        else op = OP_POWERUP;
        send_item(op, 8'($urandom), 1'($urandom), 6'($urandom_range(0, 63)), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d data, %0d command, %0d cursor and %0d power-up requests",
             ops_seen[OP_DATA], ops_seen[OP_CMD], ops_seen[OP_CURSOR], ops_seen[OP_POWERUP]);
    $display("Checked %0d pin-state items across 4-bit and 8-bit bus modes, %0d mismatches",
             pins_seen, err_count);
    if (err_count == 0 && pending_pins.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ char_lcd_write_sequencer.f @@
rtl/core/clws_pkg.sv
rtl/core/clws_ctrl.sv
rtl/core/clws_datapath.sv
rtl/core/char_lcd_write_sequencer.sv
dv/tb_char_lcd_write_sequencer.sv
